[rtl/slf_pkg.sv]
// shared types, codes and helpers for the linear trend forecaster
package slf_pkg;

  localparam int AW = 96;
  localparam int OPW = 64;
  localparam int RES_W = 48;
  localparam int FRAC_W = 12;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_TREND = 2'd2,
    CMD_FCAST = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNKNOWN     = 3'd1,
    ST_TABLE_FULL  = 3'd2,
    ST_SERIES_FULL = 3'd3,
    ST_TOO_FEW     = 3'd4,
    ST_DEGENERATE  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_EVAL, S_ADDW, S_MUL, S_CHK, S_DIV, S_TRD, S_FC
  } state_t;

  typedef enum logic [2:0] {
    OP_NSXY, OP_SXSY, OP_NSXX, OP_SXSX, OP_SLSX, OP_SLNEW, OP_SLDELTA
  } mop_t;

  typedef struct packed {
    logic        [10:0] cnt;
    logic signed [34:0] sx;
    logic signed [34:0] sy;
    logic signed [57:0] sxy;
    logic signed [56:0] sxx;
    logic signed [23:0] newest;
    logic signed [23:0] prev;
  } rec_t;

  function automatic logic signed [RES_W-1:0] sat48(input logic signed [AW-1:0] v);
    logic [AW-RES_W:0] top;
    top = v[AW-1:RES_W-1];
    if ((&top) || (~|top)) return v[RES_W-1:0];
    else if (v[AW-1]) return {1'b1, {(RES_W-1){1'b0}}};
    else return {1'b0, {(RES_W-1){1'b1}}};
  endfunction

endpackage

[rtl/slf_in_if.sv]
// command word channel
interface slf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [3:0]         series;
  logic signed [23:0] value;
  logic signed [23:0] timestamp;
  logic [6:0]         horizon;
  modport source(output valid, cmd, series, value, timestamp, horizon, input ready);
  modport sink(input valid, cmd, series, value, timestamp, horizon, output ready);
endinterface

[rtl/slf_out_if.sv]
// result word channel
interface slf_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [3:0]         series_index;
  logic signed [47:0] slope;
  logic signed [47:0] intercept;
  logic signed [47:0] forecast_value;
  logic [6:0]         step;
  logic               last;
  modport source(output valid, status, series_index, slope, intercept, forecast_value,
                 step, last, input ready);
  modport sink(input valid, status, series_index, slope, intercept, forecast_value,
               step, last, output ready);
endinterface

[rtl/slf_mul.sv]
// sequential signed multiplier, eight multiplier bits per cycle
module slf_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [slf_pkg::OPW-1:0] a,
  input  logic signed [slf_pkg::OPW-1:0] b,
  output logic                           done,
  output logic signed [slf_pkg::AW-1:0]  p
);
  localparam int DIG = 8;
  localparam int STEPS = slf_pkg::OPW / DIG;
  localparam int CW = $clog2(STEPS);

  logic                          busy_r;
  logic                          done_r;
  logic [CW-1:0]                 cnt_r;
  logic [slf_pkg::OPW-1:0]       mcand_r;
  logic [2*slf_pkg::OPW-1:0]     prod_r;
  logic                          neg_r;
  logic [slf_pkg::OPW-1:0]       ma, mb;
  logic [slf_pkg::OPW+DIG-1:0]   sum;
  logic [slf_pkg::AW-1:0]        mag;

  assign ma = a[slf_pkg::OPW-1] ? (~a + 1'b1) : a;
  assign mb = b[slf_pkg::OPW-1] ? (~b + 1'b1) : b;
  assign sum = {{DIG{1'b0}}, prod_r[2*slf_pkg::OPW-1:slf_pkg::OPW]}
             + ({{DIG{1'b0}}, mcand_r} * {{slf_pkg::OPW{1'b0}}, prod_r[DIG-1:0]});
  assign mag = prod_r[slf_pkg::AW-1:0];
  assign p = neg_r ? (~mag + 1'b1) : mag;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      mcand_r <= ma;
      prod_r  <= {{slf_pkg::OPW{1'b0}}, mb};
      neg_r   <= a[slf_pkg::OPW-1] ^ b[slf_pkg::OPW-1];
    end else if (busy_r) begin
      prod_r <= {sum, prod_r[slf_pkg::OPW-1:DIG]};
    end
  end
endmodule

[rtl/slf_div.sv]
// restoring signed divider, one quotient bit per cycle, truncating
module slf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [slf_pkg::AW-1:0] num,
  input  logic signed [slf_pkg::AW-1:0] den,
  output logic                          done,
  output logic signed [slf_pkg::AW-1:0] q
);
  localparam int W = slf_pkg::AW;
  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W:0]    rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic          neg_r;
  logic [W-1:0]  mn, md;
  logic [W:0]    sh;
  logic          ge;

  assign mn = num[W-1] ? (~num + 1'b1) : num;
  assign md = den[W-1] ? (~den + 1'b1) : den;
  assign sh = {rem_r[W-1:0], quo_r[W-1]};
  assign ge = sh >= {1'b0, dvs_r};
  assign q = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= mn;
      dvs_r <= md;
      neg_r <= num[W-1] ^ den[W-1];
    end else if (busy_r) begin
      rem_r <= ge ? (sh - {1'b0, dvs_r}) : sh;
      quo_r <= {quo_r[W-2:0], ge};
    end
  end
endmodule

[rtl/series_linear_trend_forecaster_top.sv]
// linear trend forecaster: series table memory, sequencer, shared multiplier and divider
// open / unknown series: result from the dispatch state; add: from the write state
// trend: 5 multiplies plus 2 divisions
// forecast: trend plus 2 more multiplies, then one forecast word per cycle unless output stalls
// one command at a time; the series table memory (one read port, one write port) sets the order
// reset clears control and the series count; table entries are zeroed when a series is opened
module series_linear_trend_forecaster_top #(
  parameter int MAX_SERIES  = 16,
  parameter int MAX_POINTS  = 1024,
  parameter int MAX_HORIZON = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  slf_in_if.sink   in_ch,
  slf_out_if.source out_ch
);
  localparam int IDX_W = (MAX_SERIES > 1) ? $clog2(MAX_SERIES) : 1;
  localparam int SC_W  = $clog2(MAX_SERIES + 1);
  localparam int AW    = slf_pkg::AW;
  localparam int OPW   = slf_pkg::OPW;

  slf_pkg::state_t  state_r, state_nxt;
  slf_pkg::mop_t    op_r;
  slf_pkg::cmd_t    cmd_r;
  logic [SC_W-1:0]  ser_cnt_r;
  logic [3:0]       ser_r;
  logic signed [23:0] val_r, ts_r;
  logic [6:0]       hor_r;
  logic             launched_r;

  slf_pkg::rec_t    mem [MAX_SERIES];
  slf_pkg::rec_t    mem_q_r;
  slf_pkg::rec_t    upd, wr_data;
  logic             wr_en, rd_en, sc_inc;
  logic [IDX_W-1:0] wr_addr;

  logic signed [47:0] pxy_r, pxx_r;
  logic signed [AW-1:0] t1_r, num_r, den_r, acc_r, stepv_r;
  logic signed [47:0] slope_r, icpt_r;
  logic [6:0]       step_r;

  logic             out_valid_r;
  slf_pkg::status_t out_status_r;
  logic [3:0]       out_idx_r;
  logic signed [47:0] out_slope_r, out_icpt_r, out_fc_r;
  logic [6:0]       out_step_r;
  logic             out_last_r;

  logic             emit;
  slf_pkg::status_t e_status;
  logic [3:0]       e_idx;
  logic signed [47:0] e_slope, e_icpt, e_fc;
  logic [6:0]       e_step;
  logic             e_last;

  logic             accept, out_free;
  logic             mul_start, mul_done, div_start, div_done;
  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [AW-1:0]  mul_p, div_n, div_d, div_q;
  logic signed [24:0]    delta;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == slf_pkg::S_IDLE);
  assign delta = 25'(mem_q_r.newest) - 25'(mem_q_r.prev);

  always_comb begin
    upd        = mem_q_r;
    upd.cnt    = mem_q_r.cnt + 1'b1;
    upd.sx     = mem_q_r.sx + 35'(ts_r);
    upd.sy     = mem_q_r.sy + 35'(val_r);
    upd.sxy    = mem_q_r.sxy + 58'(pxy_r);
    upd.sxx    = mem_q_r.sxx + 57'(pxx_r);
    upd.prev   = mem_q_r.newest;
    upd.newest = ts_r;
  end

  // operand select for the shared multiplier
  always_comb begin
    case (op_r)
      slf_pkg::OP_NSXY:   begin mul_a = OPW'(mem_q_r.cnt); mul_b = OPW'(mem_q_r.sxy); end
      slf_pkg::OP_SXSY:   begin mul_a = OPW'(mem_q_r.sx);  mul_b = OPW'(mem_q_r.sy);  end
      slf_pkg::OP_NSXX:   begin mul_a = OPW'(mem_q_r.cnt); mul_b = OPW'(mem_q_r.sxx); end
      slf_pkg::OP_SXSX:   begin mul_a = OPW'(mem_q_r.sx);  mul_b = OPW'(mem_q_r.sx);  end
      slf_pkg::OP_SLSX:   begin mul_a = OPW'(slope_r);     mul_b = OPW'(mem_q_r.sx);  end
      slf_pkg::OP_SLNEW:  begin mul_a = OPW'(slope_r);     mul_b = OPW'(mem_q_r.newest); end
      slf_pkg::OP_SLDELTA: begin mul_a = OPW'(slope_r);    mul_b = OPW'(delta);       end
      default:            begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  // slope division first, then the intercept division by n
  always_comb begin
    if (op_r == slf_pkg::OP_SXSX) begin
      div_n = num_r <<< slf_pkg::FRAC_W;
      div_d = den_r;
    end else begin
      div_n = (AW'(mem_q_r.sy) <<< slf_pkg::FRAC_W) - t1_r;
      div_d = AW'(mem_q_r.cnt);
    end
  end

  slf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  slf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .q(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= slf_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    e_status  = slf_pkg::ST_OK;
    e_idx     = ser_r;
    e_slope   = '0;
    e_icpt    = '0;
    e_fc      = '0;
    e_step    = '0;
    e_last    = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = IDX_W'(ser_r);
    wr_data   = upd;
    rd_en     = 1'b0;
    sc_inc    = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      slf_pkg::S_IDLE: begin
        if (accept) state_nxt = slf_pkg::S_DISP;
      end
      slf_pkg::S_DISP: begin
        if (cmd_r == slf_pkg::CMD_OPEN) begin
          if (out_free) begin
            emit = 1'b1;
            state_nxt = slf_pkg::S_IDLE;
            if (32'(ser_cnt_r) >= MAX_SERIES) begin
              e_status = slf_pkg::ST_TABLE_FULL;
              e_idx    = '0;
            end else begin
              e_idx   = 4'(ser_cnt_r);
              wr_en   = 1'b1;
              wr_addr = IDX_W'(ser_cnt_r);
              wr_data = '0;
              sc_inc  = 1'b1;
            end
          end
        end else if (32'(ser_r) >= 32'(ser_cnt_r)) begin
          if (out_free) begin
            emit = 1'b1;
            e_status = slf_pkg::ST_UNKNOWN;
            state_nxt = slf_pkg::S_IDLE;
          end
        end else begin
          rd_en = 1'b1;
          state_nxt = slf_pkg::S_EVAL;
        end
      end
      slf_pkg::S_EVAL: begin
        if (cmd_r == slf_pkg::CMD_ADD) begin
          if (32'(mem_q_r.cnt) >= MAX_POINTS) begin
            if (out_free) begin
              emit = 1'b1;
              e_status = slf_pkg::ST_SERIES_FULL;
              state_nxt = slf_pkg::S_IDLE;
            end
          end else begin
            state_nxt = slf_pkg::S_ADDW;
          end
        end else if (mem_q_r.cnt < 11'd2) begin
          if (out_free) begin
            emit = 1'b1;
            e_status = slf_pkg::ST_TOO_FEW;
            state_nxt = slf_pkg::S_IDLE;
          end
        end else begin
          state_nxt = slf_pkg::S_MUL;
        end
      end
      slf_pkg::S_ADDW: begin
        if (out_free) begin
          emit = 1'b1;
          wr_en = 1'b1;
          state_nxt = slf_pkg::S_IDLE;
        end
      end
      slf_pkg::S_MUL: begin
        mul_start = !launched_r;
        if (mul_done) begin
          case (op_r)
            slf_pkg::OP_SXSX:    state_nxt = slf_pkg::S_CHK;
            slf_pkg::OP_SLSX:    state_nxt = slf_pkg::S_DIV;
            slf_pkg::OP_SLDELTA: state_nxt = slf_pkg::S_FC;
            default:             state_nxt = slf_pkg::S_MUL;
          endcase
        end
      end
      slf_pkg::S_CHK: begin
        if (den_r == '0) begin
          if (out_free) begin
            emit = 1'b1;
            e_status = slf_pkg::ST_DEGENERATE;
            state_nxt = slf_pkg::S_IDLE;
          end
        end else begin
          state_nxt = slf_pkg::S_DIV;
        end
      end
      slf_pkg::S_DIV: begin
        div_start = !launched_r;
        if (div_done) begin
          if (op_r == slf_pkg::OP_SXSX) state_nxt = slf_pkg::S_MUL;
          else                          state_nxt = slf_pkg::S_TRD;
        end
      end
      slf_pkg::S_TRD: begin
        if (cmd_r == slf_pkg::CMD_TREND || hor_r == '0) begin
          if (out_free) begin
            emit = 1'b1;
            e_slope = slope_r;
            e_icpt  = icpt_r;
            state_nxt = slf_pkg::S_IDLE;
          end
        end else begin
          state_nxt = slf_pkg::S_MUL;
        end
      end
      slf_pkg::S_FC: begin
        if (out_free) begin
          emit = 1'b1;
          e_slope = slope_r;
          e_icpt  = icpt_r;
          e_fc    = slf_pkg::sat48(acc_r);
          e_step  = step_r;
          e_last  = (step_r == hor_r);
          if (step_r == hor_r) state_nxt = slf_pkg::S_IDLE;
        end
      end
      default: state_nxt = slf_pkg::S_IDLE;
    endcase
  end

  // series table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q_r <= mem[IDX_W'(ser_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_cnt_r  <= '0;
      launched_r <= 1'b0;
    end else begin
      if (sc_inc) ser_cnt_r <= ser_cnt_r + SC_W'(1);
      if (mul_done || div_done)        launched_r <= 1'b0;
      else if (mul_start || div_start) launched_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= slf_pkg::cmd_t'(in_ch.cmd);
      ser_r <= in_ch.series;
      val_r <= in_ch.value;
      ts_r  <= in_ch.timestamp;
      hor_r <= (32'(in_ch.horizon) > MAX_HORIZON) ? 7'(MAX_HORIZON) : in_ch.horizon;
    end
    case (state_r)
      slf_pkg::S_EVAL: begin
        pxy_r <= ts_r * val_r;
        pxx_r <= ts_r * ts_r;
        op_r  <= slf_pkg::OP_NSXY;
      end
      slf_pkg::S_MUL: begin
        if (mul_done) begin
          case (op_r)
            slf_pkg::OP_NSXY: begin t1_r <= mul_p; op_r <= slf_pkg::OP_SXSY; end
            slf_pkg::OP_SXSY: begin num_r <= t1_r - mul_p; op_r <= slf_pkg::OP_NSXX; end
            slf_pkg::OP_NSXX: begin t1_r <= mul_p; op_r <= slf_pkg::OP_SXSX; end
            slf_pkg::OP_SXSX: den_r <= t1_r - mul_p;
            slf_pkg::OP_SLSX: t1_r <= mul_p;
            slf_pkg::OP_SLNEW: begin
              acc_r <= AW'(icpt_r) + mul_p;
              op_r  <= slf_pkg::OP_SLDELTA;
            end
            slf_pkg::OP_SLDELTA: begin
              // first forecast sits one gap past the newest time
              stepv_r <= mul_p;
              acc_r   <= acc_r + mul_p;
              step_r  <= 7'd1;
            end
            default: op_r <= op_r;
          endcase
        end
      end
      slf_pkg::S_DIV: begin
        if (div_done) begin
          if (op_r == slf_pkg::OP_SXSX) begin
            slope_r <= slf_pkg::sat48(div_q);
            op_r    <= slf_pkg::OP_SLSX;
          end else begin
            icpt_r <= slf_pkg::sat48(div_q);
          end
        end
      end
      slf_pkg::S_TRD: op_r <= slf_pkg::OP_SLNEW;
      slf_pkg::S_FC: begin
        if (out_free) begin
          acc_r  <= acc_r + stepv_r;
          step_r <= step_r + 7'd1;
        end
      end
      default: op_r <= op_r;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n)              out_valid_r <= 1'b0;
    else if (emit)           out_valid_r <= 1'b1;
    else if (out_ch.ready)   out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= e_status;
      out_idx_r    <= e_idx;
      out_slope_r  <= e_slope;
      out_icpt_r   <= e_icpt;
      out_fc_r     <= e_fc;
      out_step_r   <= e_step;
      out_last_r   <= e_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.series_index   = out_idx_r;
  assign out_ch.slope          = out_slope_r;
  assign out_ch.intercept      = out_icpt_r;
  assign out_ch.forecast_value = out_fc_r;
  assign out_ch.step           = out_step_r;
  assign out_ch.last           = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ser_cnt_r) <= MAX_SERIES) else $error("series count past table size");
  a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == slf_pkg::S_MUL) else $error("multiplier result unclaimed");
  a_fc_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_step_r != '0 && out_step_r == hor_r) |-> out_last_r)
    else $error("final forecast word not marked last");
`endif
endmodule
